/* rtl/mtwm_pkg.sv */
// Package for the monospace text width meter: widths, codes, shared types.
// Used by the channel interfaces and by every module of the block.
package mtwm_pkg;

    // Absolute pel position width
    localparam int POSITION_BITS = 20;

    // Fixed field widths
    localparam int CU_BITS   = 16;
    localparam int SX_BITS   = 20;
    localparam int OUT_BITS  = 20;
    localparam int CW_BITS   = 10;
    localparam int TAB_BITS  = 16;
    localparam int INC_BITS  = CW_BITS + 1;

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam logic [CFG_IDX_BITS-1:0] CFG_AVG_WIDTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_INC   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TAB_SIZE  = 2'd2;

    localparam logic [CW_BITS-1:0]  AVG_RESET = 10'd8;
    localparam logic [CW_BITS-1:0]  MAX_RESET = 10'd8;
    localparam logic [TAB_BITS-1:0] TAB_RESET = 16'd64;

    // Tab character
    localparam logic [CU_BITS-1:0] TAB_CODE = 16'h0009;

    // Derived arithmetic widths
    localparam int CMP_BITS = (POSITION_BITS > SX_BITS) ? POSITION_BITS : SX_BITS;
    localparam int DIV_BITS = POSITION_BITS + 1;
    localparam int TGT_BITS = ((DIV_BITS > TAB_BITS) ? DIV_BITS : TAB_BITS) + 1;
    localparam int CNT_BITS = $clog2(DIV_BITS);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

    // Item queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    // Classified request as it travels through the queue
    typedef struct packed {
        logic                     is_tab;
        logic                     first;
        logic                     sat_start;
        logic [INC_BITS-1:0]      inc;
        logic [POSITION_BITS-1:0] start;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic pop;
        logic dividing;
    } t_back_stat;

endpackage

/* rtl/mtwm_in_if.sv */
// Channel interfaces of the text width meter: input requests, results, config.
// Depends on mtwm_pkg for field widths.
interface mtwm_in_if;
    logic                         valid;
    logic                         ready;
    logic [mtwm_pkg::CU_BITS-1:0] code_unit;
    logic                         first;
    logic [mtwm_pkg::SX_BITS-1:0] start_x;

    modport source (output valid, code_unit, first, start_x, input ready);
    modport sink   (input valid, code_unit, first, start_x, output ready);
endinterface

interface mtwm_out_if;
    logic                          valid;
    logic                          ready;
    logic [mtwm_pkg::OUT_BITS-1:0] advance;
    logic [mtwm_pkg::OUT_BITS-1:0] total_width;
    logic                          saturated;

    modport source (output valid, advance, total_width, saturated, input ready);
    modport sink   (input valid, advance, total_width, saturated, output ready);
endinterface

interface mtwm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mtwm_pkg::CFG_IDX_BITS-1:0]  wr_index;
    logic [mtwm_pkg::CFG_DATA_BITS-1:0] wr_data;

    modport source (output valid, wr_index, wr_data, input ready);
    modport sink   (input valid, wr_index, wr_data, output ready);
endinterface

/* rtl/mtwm_front.sv */
// Front end: takes input requests, clamps the start position and classifies
// each code unit into a tab or a fixed increment. Depends on mtwm_pkg, mtwm_in_if.
module mtwm_front (
    mtwm_in_if.sink                       i_meas,
    input  logic [mtwm_pkg::CW_BITS-1:0]  i_avg_width,
    input  logic [mtwm_pkg::CW_BITS-1:0]  i_max_inc,
    input  logic                          i_q_full,
    output logic                          o_push,
    output mtwm_pkg::t_item               o_item
);
    import mtwm_pkg::*;

    function automatic logic in_range(input logic [CU_BITS-1:0] c,
                                      input logic [CU_BITS-1:0] lo,
                                      input logic [CU_BITS-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // Maximum increment width in hybrid CJK mode
    function automatic logic is_cjk_wide(input logic [CU_BITS-1:0] c);
        return in_range(c, 16'h0400, 16'h044F) || (c == 16'h00A8) || (c == 16'h00B4) ||
               in_range(c, 16'h2010, 16'h203B) || in_range(c, 16'h2100, 16'hA6FF) ||
               in_range(c, 16'hAC00, 16'hFF5F);
    endfunction

    function automatic logic is_wide(input logic [CU_BITS-1:0] c);
        return in_range(c, 16'h1100, 16'h11FF) || in_range(c, 16'h2E80, 16'hA4CF) ||
               in_range(c, 16'hAC00, 16'hD7AF) || in_range(c, 16'hF900, 16'hFAFF) ||
               in_range(c, 16'hFE30, 16'hFE4F) || in_range(c, 16'hFF00, 16'hFF5F);
    endfunction

    function automatic logic is_zero_width(input logic [CU_BITS-1:0] c);
        return in_range(c, 16'h200B, 16'h200F);
    endfunction

    logic                hybrid;
    logic [CMP_BITS-1:0] sx_ext;
    logic                sx_over;

    assign i_meas.ready = !i_q_full;
    assign o_push       = i_meas.valid && !i_q_full;

    // Start position clamp
    assign sx_ext  = CMP_BITS'(i_meas.start_x);
    assign sx_over = sx_ext > CMP_BITS'(POS_MAX);

    assign hybrid = i_max_inc > i_avg_width;

    // Classification
    always_comb begin
        o_item.is_tab    = (i_meas.code_unit == TAB_CODE);
        o_item.first     = i_meas.first;
        o_item.sat_start = i_meas.first && sx_over;
        o_item.start     = sx_over ? POS_MAX : sx_ext[POSITION_BITS-1:0];
        if (hybrid && is_cjk_wide(i_meas.code_unit)) begin
            o_item.inc = {1'b0, i_max_inc};
        end else if (is_wide(i_meas.code_unit)) begin
            o_item.inc = {i_avg_width, 1'b0};
        end else if (is_zero_width(i_meas.code_unit)) begin
            o_item.inc = '0;
        end else begin
            o_item.inc = {1'b0, i_avg_width};
        end
    end

endmodule

/* rtl/mtwm_queue.sv */
// Short request queue between the front end and the position unit.
// Depends on mtwm_pkg.
module mtwm_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mtwm_pkg::t_item   i_item,
    input  logic              i_pop,
    output mtwm_pkg::t_item   o_head,
    output mtwm_pkg::t_q_stat o_stat
);
    import mtwm_pkg::*;

    t_item                 r_mem [QUEUE_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count, n_count;

    assign o_stat.full  = (r_count == Q_CNT_BITS'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/mtwm_back.sv */
// Position unit: applies queued requests to the pel position, rounds tabs up
// with a bit-serial remainder unit, and holds the result register.
// Depends on mtwm_pkg and mtwm_out_if.
module mtwm_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [mtwm_pkg::CW_BITS-1:0]   i_avg_width,
    input  logic [mtwm_pkg::TAB_BITS-1:0]  i_tab_size,
    input  mtwm_pkg::t_item                i_head,
    input  logic                           i_q_empty,
    output mtwm_pkg::t_back_stat           o_stat,
    mtwm_out_if.source                     o_res
);
    import mtwm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]               r_state, n_state;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic                     r_sat, n_sat;
    logic [DIV_BITS-1:0]      r_sum, n_sum;
    logic [DIV_BITS-1:0]      r_shift, n_shift;
    logic [TAB_BITS-1:0]      r_rem, n_rem;
    logic [CNT_BITS-1:0]      r_cnt, n_cnt;

    logic                r_out_valid;
    logic [OUT_BITS-1:0] r_advance;
    logic [OUT_BITS-1:0] r_total;
    logic                r_saturated;

    logic                     slot_free;
    logic [TAB_BITS-1:0]      tab_eff;
    logic [POSITION_BITS-1:0] hd_base, hd_start;
    logic [TAB_BITS:0]        cand;
    logic [TGT_BITS-1:0]      done_target;
    logic                     pop;
    logic                     fin;
    logic [POSITION_BITS-1:0] fin_base, fin_start, fin_pos;
    logic [TGT_BITS-1:0]      fin_target;
    logic                     fin_sat, fin_over;
    logic [POSITION_BITS-1:0] adv_raw, tot_raw;
    logic [CMP_BITS-1:0]      adv_ext, tot_ext;

    assign slot_free = !r_out_valid || o_res.ready;
    assign tab_eff   = (i_tab_size == '0) ? TAB_BITS'(1) : i_tab_size;
    assign hd_base   = i_head.first ? i_head.start : r_pos;
    assign hd_start  = i_head.first ? i_head.start : r_start;

    // One remainder step: bring in the next dividend bit
    assign cand = {r_rem, r_shift[DIV_BITS-1]};

    // Next tab stop beyond position + average width
    assign done_target = TGT_BITS'(r_sum) - TGT_BITS'(r_rem) + TGT_BITS'(tab_eff);

    // Sequencer
    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_start    = r_start;
        n_sat      = r_sat;
        n_sum      = r_sum;
        n_shift    = r_shift;
        n_rem      = r_rem;
        n_cnt      = r_cnt;
        pop        = 1'b0;
        fin        = 1'b0;
        fin_base   = r_pos;
        fin_start  = r_start;
        fin_target = done_target;
        fin_sat    = r_sat;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    if (i_head.is_tab) begin
                        pop     = 1'b1;
                        n_pos   = hd_base;
                        n_start = hd_start;
                        n_sat   = i_head.sat_start;
                        n_sum   = DIV_BITS'(hd_base) + DIV_BITS'(i_avg_width);
                        n_shift = DIV_BITS'(hd_base) + DIV_BITS'(i_avg_width);
                        n_rem   = '0;
                        n_cnt   = CNT_BITS'(DIV_BITS - 1);
                        n_state = ST_DIV;
                    end else if (slot_free) begin
                        pop        = 1'b1;
                        fin        = 1'b1;
                        fin_base   = hd_base;
                        fin_start  = hd_start;
                        fin_target = TGT_BITS'(hd_base) + TGT_BITS'(i_head.inc);
                        fin_sat    = i_head.sat_start;
                    end
                end
            end
            ST_DIV: begin
                if (cand >= {1'b0, tab_eff}) begin
                    n_rem = TAB_BITS'(cand - {1'b0, tab_eff});
                end else begin
                    n_rem = cand[TAB_BITS-1:0];
                end
                n_shift = {r_shift[DIV_BITS-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (slot_free) begin
                    fin     = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (fin) begin
            n_pos   = fin_pos;
            n_start = fin_start;
        end
    end

    // Clamp at the position maximum and form the result fields
    assign fin_over = fin_target > TGT_BITS'(POS_MAX);
    assign fin_pos  = fin_over ? POS_MAX : fin_target[POSITION_BITS-1:0];
    assign adv_raw  = fin_pos - fin_base;
    assign tot_raw  = fin_pos - fin_start;
    assign adv_ext  = CMP_BITS'(adv_raw);
    assign tot_ext  = CMP_BITS'(tot_raw);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_start <= n_start;
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_sat   <= n_sat;
        r_sum   <= n_sum;
        r_shift <= n_shift;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
        if (fin) begin
            r_advance   <= adv_ext[OUT_BITS-1:0];
            r_total     <= tot_ext[OUT_BITS-1:0];
            r_saturated <= fin_sat || fin_over;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.advance     = r_advance;
    assign o_res.total_width = r_total;
    assign o_res.saturated   = r_saturated;

    assign o_stat.pop      = pop;
    assign o_stat.dividing = (r_state == ST_DIV);

endmodule

/* rtl/monospace_text_width_measure.sv */
// Top level of the monospace text width meter: config registers, front end,
// request queue and position unit. Depends on mtwm_pkg, the mtwm interfaces,
// mtwm_front, mtwm_queue and mtwm_back.
//
// Usage:
//   i_meas takes one UCS-2 code unit per request with a first flag and a start
//   position; o_res returns one result per request (advance, running width,
//   saturated) in request order. i_cfg writes average width (index 0),
//   maximum increment (index 1) and tab size (index 2); it is always ready
//   and is meant to be written only while no request is in flight.
// Throughput:
//   An ordinary character passes through the request queue and the result
//   register, and such characters stream at one per cycle while o_res is taken. A
//   tab runs a bit-serial remainder unit, one dividend bit per cycle, and the
//   position unit works on one tab at a time.
// Reset:
//   Synchronous, active low. Registers return to 8 / 8 / 64, the position and
//   string start to 0, and the queue and result register empty.
// Stall:
//   While o_res is not taken the result holds; the two-entry queue fills and
//   then i_meas.ready drops.
module monospace_text_width_measure (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtwm_in_if.sink     i_meas,
    mtwm_cfg_if.sink    i_cfg,
    mtwm_out_if.source  o_res
);
    import mtwm_pkg::*;

    logic [CW_BITS-1:0]  r_avg_width;
    logic [CW_BITS-1:0]  r_max_inc;
    logic [TAB_BITS-1:0] r_tab_size;

    logic       q_push;
    t_item      q_in_item;
    t_item      q_head;
    t_q_stat    q_stat;
    t_back_stat b_stat;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_width <= AVG_RESET;
            r_max_inc   <= MAX_RESET;
            r_tab_size  <= TAB_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.wr_index)
                CFG_AVG_WIDTH: r_avg_width <= i_cfg.wr_data[CW_BITS-1:0];
                CFG_MAX_INC:   r_max_inc   <= i_cfg.wr_data[CW_BITS-1:0];
                CFG_TAB_SIZE:  r_tab_size  <= i_cfg.wr_data[TAB_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    mtwm_front u_front (
        .i_meas      (i_meas),
        .i_avg_width (r_avg_width),
        .i_max_inc   (r_max_inc),
        .i_q_full    (q_stat.full),
        .o_push      (q_push),
        .o_item      (q_in_item)
    );

    mtwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (b_stat.pop),
        .o_head  (q_head),
        .o_stat  (q_stat)
    );

    mtwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_avg_width (r_avg_width),
        .i_tab_size  (r_tab_size),
        .i_head      (q_head),
        .i_q_empty   (q_stat.empty),
        .o_stat      (b_stat),
        .o_res       (o_res)
    );

`ifndef NO_ASSERTIONS
    // No request enters a full queue
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_stat.full)
        else $error("request pushed into full queue");

    // The position unit never takes from an empty queue
    a_pop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.pop |-> !q_stat.empty)
        else $error("request popped from empty queue");

    // No new request is taken while a tab is being rounded
    a_no_pop_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.dividing |-> !b_stat.pop)
        else $error("request popped during tab rounding");

    // A tab in progress leaves the result register alone
    a_div_holds_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (b_stat.dividing && !o_res.valid) |=> !o_res.valid)
        else $error("result appeared during tab rounding");
`endif

endmodule

/* tb/mtwm_width_checker.sv */
`timescale 1ns / 100ps
// Result checker for the monospace text width meter: tracks config writes and
// requests, predicts each result and compares it. Depends on mtwm_pkg and the mtwm interfaces.
module mtwm_width_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    mtwm_in_if   i_meas,
    mtwm_cfg_if  i_cfg,
    mtwm_out_if  i_res,
    output int   o_errors,
    output int   o_pending
);
    import mtwm_pkg::*;

    // Code ranges used for width classification
    localparam logic [CU_BITS-1:0] CYRIL_LO   = 16'h0400;
    localparam logic [CU_BITS-1:0] CYRIL_HI   = 16'h044F;
    localparam logic [CU_BITS-1:0] DIAERESIS  = 16'h00A8;
    localparam logic [CU_BITS-1:0] ACUTE      = 16'h00B4;
    localparam logic [CU_BITS-1:0] PUNCT_LO   = 16'h2010;
    localparam logic [CU_BITS-1:0] PUNCT_HI   = 16'h203B;
    localparam logic [CU_BITS-1:0] SYMBOL_LO  = 16'h2100;
    localparam logic [CU_BITS-1:0] SYMBOL_HI  = 16'hA6FF;
    localparam logic [CU_BITS-1:0] HANGUL_LO  = 16'hAC00;
    localparam logic [CU_BITS-1:0] HANGUL_HI  = 16'hD7AF;
    localparam logic [CU_BITS-1:0] FULL_LO    = 16'hFF00;
    localparam logic [CU_BITS-1:0] FULL_HI    = 16'hFF5F;
    localparam logic [CU_BITS-1:0] JAMO_LO    = 16'h1100;
    localparam logic [CU_BITS-1:0] JAMO_HI    = 16'h11FF;
    localparam logic [CU_BITS-1:0] RADICAL_LO = 16'h2E80;
    localparam logic [CU_BITS-1:0] YI_HI      = 16'hA4CF;
    localparam logic [CU_BITS-1:0] COMPAT_LO  = 16'hF900;
    localparam logic [CU_BITS-1:0] COMPAT_HI  = 16'hFAFF;
    localparam logic [CU_BITS-1:0] VERT_LO    = 16'hFE30;
    localparam logic [CU_BITS-1:0] VERT_HI    = 16'hFE4F;
    localparam logic [CU_BITS-1:0] ZW_LO      = 16'h200B;
    localparam logic [CU_BITS-1:0] ZW_HI      = 16'h200F;

    typedef struct packed {
        logic [OUT_BITS-1:0] advance;
        logic [OUT_BITS-1:0] total_width;
        logic                saturated;
    } t_width_result;

    t_width_result            expected_q[$];
    logic [POSITION_BITS-1:0] pel_pos;
    logic [POSITION_BITS-1:0] str_start;
    logic [CW_BITS-1:0]       avg_width;
    logic [CW_BITS-1:0]       max_inc;
    logic [TAB_BITS-1:0]      tab_pitch;
    int                       err_count = 0;

    assign o_errors = err_count;

    function automatic logic in_span(input logic [CU_BITS-1:0] c,
                                     input logic [CU_BITS-1:0] lo,
                                     input logic [CU_BITS-1:0] hi);
        return c >= lo && c <= hi;
    endfunction

    // Wide in hybrid CJK mode
    function automatic logic cjk_double(input logic [CU_BITS-1:0] c);
        return in_span(c, CYRIL_LO, CYRIL_HI) || c == DIAERESIS || c == ACUTE ||
               in_span(c, PUNCT_LO, PUNCT_HI) || in_span(c, SYMBOL_LO, SYMBOL_HI) ||
               in_span(c, HANGUL_LO, FULL_HI);
    endfunction

    function automatic logic double_width(input logic [CU_BITS-1:0] c);
        return in_span(c, JAMO_LO, JAMO_HI) || in_span(c, RADICAL_LO, YI_HI) ||
               in_span(c, HANGUL_LO, HANGUL_HI) || in_span(c, COMPAT_LO, COMPAT_HI) ||
               in_span(c, VERT_LO, VERT_HI) || in_span(c, FULL_LO, FULL_HI);
    endfunction

    function automatic logic [INC_BITS-1:0] pel_increment(input logic [CU_BITS-1:0] c);
        if (max_inc > avg_width && cjk_double(c))
            return INC_BITS'(max_inc);
        if (double_width(c))
            return {avg_width, 1'b0};
        if (in_span(c, ZW_LO, ZW_HI))
            return '0;
        return INC_BITS'(avg_width);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t ns mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
        err_count++;
    endtask

    // Follow config writes, check results, predict each accepted request
    always @(posedge i_clk) begin : track
        t_width_result want;
        logic [63:0]   base;
        logic [63:0]   target;
        logic [63:0]   pitch;
        logic          clamp;
        if (!i_rst_n) begin
            avg_width = AVG_RESET;
            max_inc   = MAX_RESET;
            tab_pitch = TAB_RESET;
            pel_pos   = '0;
            str_start = '0;
            expected_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.wr_index)
                    CFG_AVG_WIDTH: avg_width = i_cfg.wr_data[CW_BITS-1:0];
                    CFG_MAX_INC:   max_inc   = i_cfg.wr_data[CW_BITS-1:0];
                    CFG_TAB_SIZE:  tab_pitch = i_cfg.wr_data[TAB_BITS-1:0];
                    default: ;
                endcase
            end

            if (i_res.valid && i_res.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("result with no request, advance", '0,
                                    32'(i_res.advance));
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.advance !== want.advance)
                        report_mismatch("advance", 32'(want.advance),
                                        32'(i_res.advance));
                    if (i_res.total_width !== want.total_width)
                        report_mismatch("total_width", 32'(want.total_width),
                                        32'(i_res.total_width));
                    if (i_res.saturated !== want.saturated)
                        report_mismatch("saturated", 32'(want.saturated),
                                        32'(i_res.saturated));
                end
            end

            if (i_meas.valid && i_meas.ready) begin
                clamp = 1'b0;
                base  = 64'(pel_pos);
                // A new string reloads the position, clamped to the maximum
                if (i_meas.first) begin
                    base = 64'(i_meas.start_x);
                    if (base > 64'(POS_MAX)) begin
                        base  = 64'(POS_MAX);
                        clamp = 1'b1;
                    end
                    str_start = POSITION_BITS'(base);
                end
                // Tab: next stop strictly past position + average width
                if (i_meas.code_unit == TAB_CODE) begin
                    pitch  = (tab_pitch == '0) ? 64'd1 : 64'(tab_pitch);
                    target = ((base + 64'(avg_width)) / pitch + 64'd1) * pitch;
                end else begin
                    target = base + 64'(pel_increment(i_meas.code_unit));
                end
                if (target > 64'(POS_MAX)) begin
                    target = 64'(POS_MAX);
                    clamp  = 1'b1;
                end
                want.advance     = OUT_BITS'(target - base);
                want.total_width = OUT_BITS'(target - 64'(str_start));
                want.saturated   = clamp;
                pel_pos = POSITION_BITS'(target);
                expected_q.push_back(want);
            end
        end
        o_pending <= expected_q.size();
    end

endmodule

/* tb/monospace_text_width_measure_test.sv */
`timescale 1ns / 100ps
// Top of the text width meter testbench: clock, reset, request and config stimulus,
// result back-pressure and verdict.
// Depends on mtwm_pkg, the mtwm interfaces and mtwm_width_checker.
module monospace_text_width_measure_test;
    import mtwm_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 321;
    localparam int IDLE_PCT    = 11;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 40;

    // Codes just inside and just outside the width classes
    localparam logic [CU_BITS-1:0] BOUNDARY_CODES [0:26] = '{
        16'h03FF, 16'h0450, 16'h00A7, 16'h00A9, 16'h00B3, 16'h00B5, 16'h200A,
        16'h200F, 16'h2010, 16'h203C, 16'h20FF, 16'h2100, 16'h10FF, 16'h1200,
        16'h2E7F, 16'hA4D0, 16'hA700, 16'hABFF, 16'hD7B0, 16'hF8FF, 16'hFB00,
        16'hFE2F, 16'hFE50, 16'hFEFF, 16'hFF60, 16'h0008, 16'h000A
    };

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm = 1'b0;
    bit   hold_toggle = 1'b0;
    int   chk_errors;
    int   chk_pending;

    mtwm_in_if  meas();
    mtwm_cfg_if cfg();
    mtwm_out_if res();

    monospace_text_width_measure u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meas  (meas),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    mtwm_width_checker u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_meas    (meas),
        .i_cfg     (cfg),
        .i_res     (res),
        .o_errors  (chk_errors),
        .o_pending (chk_pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        bit seen;
        int hold_left;
        seen      = 1'b0;
        hold_left = 0;
        res.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_toggle != seen) begin
                seen      = hold_toggle;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                res.ready = 1'b0;
                hold_left--;
            end else begin
                res.ready = calm || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    initial begin
        #1000000;
        $display("FAIL monospace_text_width_measure");
        $finish;
    end

    function automatic logic [SX_BITS-1:0] pick_start();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
            return SX_BITS'($urandom_range(2000));
        if (sel < 7)
            return SX_BITS'(POS_MAX) - SX_BITS'($urandom_range(3000));
        return SX_BITS'($urandom);
    endfunction

    function automatic logic [CU_BITS-1:0] pick_code();
        case ($urandom_range(11))
            0, 1: return CU_BITS'($urandom_range(16'h7E, 16'h20));
            2:    return TAB_CODE;
            3:    return CU_BITS'($urandom_range(16'h044F, 16'h0400));
            4:    return ($urandom_range(1) == 0) ? 16'h00A8 : 16'h00B4;
            5: begin
                if ($urandom_range(1) == 0)
                    return CU_BITS'($urandom_range(16'h203B, 16'h2010));
                return CU_BITS'($urandom_range(16'h200F, 16'h200B));
            end
            6:    return CU_BITS'($urandom_range(16'hA6FF, 16'h2100));
            7:    return CU_BITS'($urandom_range(16'hFF5F, 16'hAC00));
            8: begin
                case ($urandom_range(3))
                    0:       return CU_BITS'($urandom_range(16'h11FF, 16'h1100));
                    1:       return CU_BITS'($urandom_range(16'hFAFF, 16'hF900));
                    2:       return CU_BITS'($urandom_range(16'hFE4F, 16'hFE30));
                    default: return CU_BITS'($urandom_range(16'hFF5F, 16'hFF00));
                endcase
            end
            9:    return CU_BITS'($urandom_range(16'hA4CF, 16'h2E80));
            10:   return BOUNDARY_CODES[$urandom_range(26)];
            default: return CU_BITS'($urandom);
        endcase
    endfunction

    // One request, with random idle cycles ahead of it
    task automatic send_request(input logic [CU_BITS-1:0] cu, input logic fst,
                                input logic [SX_BITS-1:0] sx);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            meas.valid     = 1'b0;
            meas.code_unit = CU_BITS'($urandom);
            meas.first     = 1'($urandom);
            meas.start_x   = SX_BITS'($urandom);
            @(negedge i_clk);
        end
        meas.valid     = 1'b1;
        meas.code_unit = cu;
        meas.first     = fst;
        meas.start_x   = sx;
        do @(posedge i_clk); while (!meas.ready);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic wait_idle();
        @(negedge i_clk);
        meas.valid = 1'b0;
        while (chk_pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic drive_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(negedge i_clk);
        cfg.valid    = 1'b1;
        cfg.wr_index = idx;
        cfg.wr_data  = data;
        do @(posedge i_clk); while (!cfg.ready);
    endtask

    // Unused upper data bits get random values
    task automatic write_regs(input logic [CW_BITS-1:0] avg, input logic [CW_BITS-1:0] mx,
                              input logic [TAB_BITS-1:0] tab);
        logic [CFG_DATA_BITS-CW_BITS-1:0] pad_a;
        logic [CFG_DATA_BITS-CW_BITS-1:0] pad_m;
        pad_a = (CFG_DATA_BITS-CW_BITS)'($urandom);
        pad_m = (CFG_DATA_BITS-CW_BITS)'($urandom);
        drive_reg(CFG_AVG_WIDTH, {pad_a, avg});
        drive_reg(CFG_MAX_INC, {pad_m, mx});
        drive_reg(CFG_TAB_SIZE, tab);
        @(negedge i_clk);
        cfg.valid = 1'b0;
    endtask

    // Random strings, mostly opened by a first flag
    task automatic send_strings(input int count);
        int   n;
        int   len;
        int   k;
        logic fst;
        n = 0;
        while (n < count) begin
            len = $urandom_range(24, 1);
            fst = ($urandom_range(99) < 90);
            for (k = 0; k < len && n < count; k++) begin
                send_request(pick_code(), (k == 0 && fst) || ($urandom_range(49) == 0),
                             pick_start());
                n++;
            end
        end
    endtask

    initial begin : stimulus
        int p;
        i_rst_n        = 1'b0;
        meas.valid     = 1'b0;
        meas.code_unit = '0;
        meas.first     = 1'b0;
        meas.start_x   = '0;
        cfg.valid      = 1'b0;
        cfg.wr_index   = CFG_AVG_WIDTH;
        cfg.wr_data    = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings, no first flag yet: measure from zero
        send_request(16'h0041, 1'b0, '0);
        send_request(TAB_CODE, 1'b0, '1);
        send_request(16'h1100, 1'b0, '0);
        send_request(16'h200B, 1'b0, '0);
        send_request(16'h0000, 1'b0, '0);
        send_request(16'hFFFF, 1'b0, '0);
        wait_idle();

        // Hybrid CJK mode, spare index written too
        drive_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
        write_regs(10'd5, 10'd12, 16'd7);
        send_request(16'h0400, 1'b1, 20'h12345);
        send_request(16'h044F, 1'b0, '0);
        send_request(16'h00A8, 1'b0, '0);
        send_request(16'h00B4, 1'b0, '0);
        send_request(16'h203B, 1'b0, '0);
        send_request(16'hA6FF, 1'b0, '0);
        send_request(16'hFF5F, 1'b0, '0);
        send_request(16'h1100, 1'b0, '0);
        send_request(16'h200F, 1'b0, '0);
        send_request(TAB_CODE, 1'b0, '0);
        // Start at the position maximum: everything clamps
        send_request(16'h0042, 1'b1, '1);
        send_request(TAB_CODE, 1'b0, '0);
        wait_idle();

        // Widest widths, zero tab size behaves as one
        write_regs(10'd1023, 10'd1023, 16'd0);
        send_request(16'hAC00, 1'b1, 20'hFF000);
        send_request(TAB_CODE, 1'b0, '0);
        send_request(16'hD7AF, 1'b1, '0);
        send_request(16'h0041, 1'b0, '0);
        wait_idle();

        // Zero widths, largest tab size
        write_regs(10'd0, 10'd0, 16'hFFFF);
        send_request(TAB_CODE, 1'b1, '0);
        send_request(16'h0041, 1'b0, '0);
        wait_idle();

        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: write_regs(10'd1023, 10'd1023, 16'hFFFF);
                1: write_regs(10'd0, 10'd1023, 16'd1);
                2: write_regs(10'd6, 10'd12, 16'd8);
                3: write_regs(CW_BITS'($urandom_range(40, 1)), CW_BITS'($urandom_range(80)),
                              TAB_BITS'($urandom_range(300, 1)));
                4: write_regs(CW_BITS'($urandom), CW_BITS'($urandom), TAB_BITS'($urandom));
                default: write_regs(10'd9, 10'd8, 16'd3);
            endcase
            calm = (p == 3);
            if (p == 2) begin
                // Long result hold-off while requests keep coming
                send_strings(50);
                hold_toggle = ~hold_toggle;
                send_strings(PHASE_ITEMS - 50);
            end else if (p == 4) begin
                send_strings(100);
                wait_idle();
                send_strings(PHASE_ITEMS - 100);
            end else begin
                send_strings(PHASE_ITEMS);
            end
            wait_idle();
        end
        calm = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (chk_errors == 0)
            $display("PASS monospace_text_width_measure");
        else
            $display("FAIL monospace_text_width_measure");
        $finish;
    end

endmodule
